FILE: sv/assert_macros.svh
// Assertion macros shared by the compass heading RTL.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHFX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CHFX_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/chfx_pkg.sv
// Shared types and constants of the compass heading pipeline.
// No dependencies; imported by every module of the block.
`default_nettype none

package chfx_pkg;

  localparam int RAW_W     = 16;
  localparam int CFG_W     = 24;
  localparam int PW        = RAW_W + CFG_W;
  localparam int NW        = PW + 1;
  localparam int UW        = PW + 5;
  localparam int ZW        = 32;
  localparam int DEG_FRAC  = 22;
  localparam int DW        = 9;
  localparam int TABLE_LEN = 24;

  localparam logic signed [ZW-1:0] HALF_TURN = 32'sd754974720;
  localparam logic signed [ZW-1:0] FULL_TURN = 32'sd1509949440;

  localparam logic [DW-1:0] DEG_0   = 9'd0;
  localparam logic [DW-1:0] DEG_90  = 9'd90;
  localparam logic [DW-1:0] DEG_180 = 9'd180;
  localparam logic [DW-1:0] DEG_270 = 9'd270;
  localparam logic [DW-1:0] DEG_MAX = 9'd359;

  // atan(2^-i) in degrees, DEG_FRAC fraction bits
  localparam logic signed [ZW-1:0] ATAN_TAB [TABLE_LEN] = '{
    32'sd188743680, 32'sd111421900, 32'sd58872272, 32'sd29884485,
    32'sd15000234,  32'sd7507429,   32'sd3754631,  32'sd1877430,
    32'sd938729,    32'sd469366,    32'sd234683,   32'sd117342,
    32'sd58671,     32'sd29335,     32'sd14668,    32'sd7334,
    32'sd3667,      32'sd1833,      32'sd917,      32'sd458,
    32'sd229,       32'sd115,       32'sd57,       32'sd29
  };

  typedef enum logic {
    REG_X_SCALE = 1'b0,
    REG_Y_SCALE = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [UW-1:0] u;
    logic signed [UW-1:0] v;
    logic signed [ZW-1:0] z;
    logic [NW-1:0]        m;
    logic                 spec;
    logic [DW-1:0]        spec_deg;
  } item_t;

endpackage

`default_nettype wire

FILE: sv/chfx_prep.sv
// Scale multiply and special-case classification, two register stages.
// Depends on chfx_pkg.
`default_nettype none

module chfx_prep (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [1:0]                          en_i,
  input  logic                                valid_i,
  input  logic signed [chfx_pkg::RAW_W-1:0]   raw_x_i,
  input  logic signed [chfx_pkg::RAW_W-1:0]   raw_y_i,
  input  logic signed [chfx_pkg::CFG_W-1:0]   x_scale_i,
  input  logic signed [chfx_pkg::CFG_W-1:0]   y_scale_i,
  output logic [1:0]                          valid_o,
  output chfx_pkg::item_t                     item_o
);
  import chfx_pkg::*;

  logic [1:0]           valid_q;
  logic signed [PW-1:0] x_d, y_d, x_q, y_q;
  logic [PW-1:0]        ax, ay;
  item_t                item_d, item_q;

  always_comb begin
    x_d = PW'(raw_x_i) * PW'(x_scale_i);
    y_d = PW'(raw_y_i) * PW'(y_scale_i);
  end

  always_comb begin
    ax = x_q[PW-1] ? PW'(-x_q) : PW'(x_q);
    ay = y_q[PW-1] ? PW'(-y_q) : PW'(y_q);
    item_d.m = {1'b0, ax | ay};
    if (x_q[PW-1]) begin
      item_d.u = -UW'(x_q);
      item_d.v = UW'(y_q);
      item_d.z = HALF_TURN;
    end else begin
      item_d.u = UW'(x_q);
      item_d.v = -UW'(y_q);
      item_d.z = '0;
    end
    item_d.spec     = (x_q == '0) || (y_q == '0);
    item_d.spec_deg = DEG_0;
    if (x_q == '0) begin
      if (y_q[PW-1]) begin
        item_d.spec_deg = DEG_90;
      end else if (y_q != '0) begin
        item_d.spec_deg = DEG_270;
      end
    end else if (x_q[PW-1]) begin
      item_d.spec_deg = DEG_180;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en_i[0]) valid_q[0] <= valid_i;
      if (en_i[1]) valid_q[1] <= valid_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0] && valid_i) begin
      x_q <= x_d;
      y_q <= y_d;
    end
    if (en_i[1] && valid_q[0]) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

FILE: sv/chfx_norm.sv
// Three steps of the binary normalizing shift that brings max(|u|,|v|) to bit 40.
// Depends on chfx_pkg.
`default_nettype none

module chfx_norm #(
  parameter int FIRST_SHIFT = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  chfx_pkg::item_t item_i,
  output logic            valid_o,
  output chfx_pkg::item_t item_o
);
  import chfx_pkg::*;

  logic  valid_q;
  item_t item_d, item_q;

  always_comb begin
    item_d = item_i;
    for (int k = 0; k < 3; k++) begin
      if ((item_d.m >> (NW - (FIRST_SHIFT >> k))) == '0) begin
        item_d.u = item_d.u <<< (FIRST_SHIFT >> k);
        item_d.v = item_d.v <<< (FIRST_SHIFT >> k);
        item_d.m = item_d.m << (FIRST_SHIFT >> k);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

FILE: sv/chfx_cordic_stage.sv
// One vectoring CORDIC rotation with its angle table entry.
// Depends on chfx_pkg.
`default_nettype none

module chfx_cordic_stage #(
  parameter int STAGE = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  chfx_pkg::item_t item_i,
  output logic            valid_o,
  output chfx_pkg::item_t item_o
);
  import chfx_pkg::*;

  logic                 valid_q;
  item_t                item_d, item_q;
  logic signed [UW-1:0] du, dv;

  always_comb begin
    item_d = item_i;
    du = item_i.v >>> STAGE;
    dv = item_i.u >>> STAGE;
    if (!item_i.v[UW-1]) begin
      item_d.u = item_i.u + du;
      item_d.v = item_i.v - dv;
      item_d.z = item_i.z + ATAN_TAB[STAGE];
    end else begin
      item_d.u = item_i.u - du;
      item_d.v = item_i.v + dv;
      item_d.z = item_i.z - ATAN_TAB[STAGE];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

FILE: sv/compass_heading_from_xy_top.sv
// Compass heading from one X/Y magnetometer word: each axis is scaled by its
// signed Q2.22 calibration register, and the heading (-atan2(y,x)) mod 360 is
// returned in whole degrees (0..359, truncated). The pipeline takes one word
// per clock unless the output side stalls; registers hold the multiply and
// classify, the normalization, each CORDIC rotation and the output value.
// A stall on the output side holds only the stages that are full. Write the
// calibration registers while idle.
// Depends on chfx_pkg, chfx_prep, chfx_norm, chfx_cordic_stage, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module compass_heading_from_xy_top #(
  parameter int ANGLE_STEPS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [31:0]                     s_axis_tdata,   // raw_x [15:0], raw_y [31:16]
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [15:0]                     m_axis_tdata,   // heading_deg [8:0], zero above
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [chfx_pkg::CFG_W-1:0]      cfg_data_i
);
  import chfx_pkg::*;

  localparam int NSTEP = (ANGLE_STEPS > TABLE_LEN) ? TABLE_LEN : ANGLE_STEPS;
  localparam int NS    = NSTEP + 5;

  logic signed [CFG_W-1:0] x_scale_q, y_scale_q;
  logic [NS-1:0]           vld, adv;
  item_t                   prep_item, norm_item;
  item_t                   cd_item [NSTEP+1];

  logic                    out_valid_q;
  logic [DW-1:0]           heading_d, heading_q;
  logic signed [ZW:0]      t;
  logic [ZW-DEG_FRAC-1:0]  deg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_scale_q <= -24'sd6000;
      y_scale_q <= 24'sd5975;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_X_SCALE: x_scale_q <= cfg_data_i;
        REG_Y_SCALE: y_scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // advance a stage when it is empty or the next one advances
  for (genvar k = 0; k < NS - 1; k++) begin : g_adv
    assign adv[k] = !vld[k] | adv[k+1];
  end
  assign adv[NS-1] = !vld[NS-1] | m_axis_tready;

  chfx_prep u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv[1:0]),
    .valid_i   (s_axis_tvalid),
    .raw_x_i   (s_axis_tdata[15:0]),
    .raw_y_i   (s_axis_tdata[31:16]),
    .x_scale_i (x_scale_q),
    .y_scale_i (y_scale_q),
    .valid_o   (vld[1:0]),
    .item_o    (prep_item)
  );

  chfx_norm #(.FIRST_SHIFT(32)) u_norm_hi (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv[2]),
    .valid_i (vld[1]),
    .item_i  (prep_item),
    .valid_o (vld[2]),
    .item_o  (norm_item)
  );

  chfx_norm #(.FIRST_SHIFT(4)) u_norm_lo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv[3]),
    .valid_i (vld[2]),
    .item_i  (norm_item),
    .valid_o (vld[3]),
    .item_o  (cd_item[0])
  );

  for (genvar i = 0; i < NSTEP; i++) begin : g_cordic
    chfx_cordic_stage #(.STAGE(i)) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv[i+4]),
      .valid_i (vld[i+3]),
      .item_i  (cd_item[i]),
      .valid_o (vld[i+4]),
      .item_o  (cd_item[i+1])
    );
  end

  always_comb begin
    t = (ZW+1)'(cd_item[NSTEP].z);
    if (t < 0) t = t + (ZW+1)'(FULL_TURN);
    if (t < 0) t = '0;
    deg = t[ZW-1:DEG_FRAC];
    if (cd_item[NSTEP].spec) begin
      heading_d = cd_item[NSTEP].spec_deg;
    end else if (deg > (ZW-DEG_FRAC)'(DEG_MAX)) begin
      heading_d = DEG_MAX;
    end else begin
      heading_d = deg[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv[NS-1]) begin
      out_valid_q <= vld[NS-2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[NS-1] && vld[NS-2]) begin
      heading_q <= heading_d;
    end
  end

  assign vld[NS-1]     = out_valid_q;
  assign s_axis_tready = adv[0];
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(16-DW)'(0), heading_q};

  `CHFX_ASSERT_IMP(a_heading_range, out_valid_q, heading_q <= DEG_MAX, "heading out of range")
  `CHFX_ASSERT_IMP(a_ready_when_empty, !out_valid_q, s_axis_tready, "input stalled with empty output")
  `CHFX_ASSERT_NXT(a_accept_loads, s_axis_tvalid && s_axis_tready, vld[0], "accepted word lost")

endmodule

`default_nettype wire

FILE: tb/tb_compass_heading_from_xy_top.sv
// Testbench for compass_heading_from_xy_top: drives raw X/Y words through the stream
// ports and checks each heading against a fixed value or a CORDIC predictor in the testbench.
// Depends on chfx_pkg and the compass heading RTL.
`default_nettype none

module tb_compass_heading_from_xy_top;
  import chfx_pkg::*;

  localparam int STEPS        = 16;
  localparam int IDLE_PCT     = 38;
  localparam int HOLD_CYCLES  = 200;
  localparam int QUIET_LIMIT  = 3000;
  localparam int PHASE_WORDS  = 55;
  localparam int NUM_PHASES   = 8;
  localparam int FROM_MODEL   = -1;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [31:0]            s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [15:0]            m_axis_tdata;
  logic                   cfg_we_i;
  cfg_reg_e               cfg_idx_i;
  logic [CFG_W-1:0]       cfg_data_i;

  logic signed [CFG_W-1:0] scale_x;
  logic signed [CFG_W-1:0] scale_y;
  logic [DW-1:0]           heading_q [$];
  int                      bad_cnt;
  bit                      calm;
  bit                      hold_req;

  typedef struct {
    logic [15:0] rx;
    logic [15:0] ry;
    int          want;
  } vec_row_t;

  // reset scales: X negative, Y positive
  vec_row_t vec_tab [19] = '{
    '{16'h0000, 16'h0000, 0},
    '{16'h0000, 16'h0001, 270},
    '{16'h0000, 16'hFFFF, 90},
    '{16'h0001, 16'h0000, 180},
    '{16'hFFFF, 16'h0000, 0},
    '{16'h7FFF, 16'h0000, 180},
    '{16'h8000, 16'h0000, 0},
    '{16'h0000, 16'h7FFF, 270},
    '{16'h0000, 16'h8000, 90},
    '{16'h8000, 16'h0001, FROM_MODEL},
    '{16'h8000, 16'hFFFF, FROM_MODEL},
    '{16'h7FFF, 16'h7FFF, FROM_MODEL},
    '{16'h8000, 16'h8000, FROM_MODEL},
    '{16'h7FFF, 16'h8000, FROM_MODEL},
    '{16'h8000, 16'h7FFF, FROM_MODEL},
    '{16'hFFFF, 16'hFFFF, FROM_MODEL},
    '{16'h0001, 16'h0001, FROM_MODEL},
    '{16'h5555, 16'hAAAA, FROM_MODEL},
    '{16'hAAAA, 16'h5555, FROM_MODEL}
  };

  compass_heading_from_xy_top #(
    .ANGLE_STEPS(STEPS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  function automatic logic [DW-1:0] heading_for(logic signed [15:0] rx,
                                                logic signed [15:0] ry,
                                                logic signed [CFG_W-1:0] sx,
                                                logic signed [CFG_W-1:0] sy);
    longint px, py, u, v, z, du, dv, t, d, lim;
    px  = longint'(rx) * longint'(sx);
    py  = longint'(ry) * longint'(sy);
    lim = 64'sd1 <<< 40;
    if (px == 0) begin
      if (py < 0) return DEG_90;
      if (py > 0) return DEG_270;
      return DEG_0;
    end
    if (py == 0) return (px > 0) ? DEG_0 : DEG_180;
    u = px;
    v = -py;
    z = 0;
    if (u < 0) begin
      u = -u;
      v = -v;
      z = longint'(HALF_TURN);
    end
    while ((u < 0 ? -u : u) < lim && (v < 0 ? -v : v) < lim) begin
      u = u * 2;
      v = v * 2;
    end
    for (int i = 0; i < STEPS && i < TABLE_LEN; i++) begin
      du = v >>> i;
      dv = u >>> i;
      if (v >= 0) begin
        u = u + du;
        v = v - dv;
        z = z + longint'(ATAN_TAB[i]);
      end else begin
        u = u - du;
        v = v + dv;
        z = z - longint'(ATAN_TAB[i]);
      end
    end
    t = z;
    if (t < 0) t = t + longint'(FULL_TURN);
    if (t < 0) t = 0;
    d = t >>> DEG_FRAC;
    if (d >= 360) return DEG_MAX;
    return d[DW-1:0];
  endfunction

  function automatic logic [15:0] pick_raw();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) return 16'h0000;
    if (sel < 20) return 16'($signed($urandom_range(8)) - 4);
    if (sel < 28) return ($urandom_range(1) != 0) ? 16'h7FFF : 16'h8000;
    return 16'($urandom);
  endfunction

  task automatic send_word(input logic [15:0] rx, input logic [15:0] ry, input int want);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ry, rx};
    do @(posedge clk_i); while (!s_axis_tready);
    if (want < 0) heading_q.push_back(heading_for(rx, ry, scale_x, scale_y));
    else heading_q.push_back(want[DW-1:0]);
    @(negedge clk_i);
  endtask

  task automatic load_scales(input logic [CFG_W-1:0] sx, input logic [CFG_W-1:0] sy);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_X_SCALE;
    cfg_data_i <= sx;
    @(negedge clk_i);
    cfg_idx_i  <= REG_Y_SCALE;
    cfg_data_i <= sy;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    scale_x = sx;
    scale_y = sy;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (heading_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    repeat (STEPS + 6) @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    logic [DW-1:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (heading_q.size() == 0) begin
        bad_cnt++;
        if (bad_cnt <= 10) $display("unexpected word: heading %0d", m_axis_tdata);
      end else begin
        want = heading_q.pop_front();
        if (m_axis_tdata !== {7'd0, want}) begin
          bad_cnt++;
          if (bad_cnt <= 10)
            $display("heading mismatch: expected %0d, got %0d", want, m_axis_tdata);
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [CFG_W-1:0] sx, sy;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_X_SCALE;
    cfg_data_i    = '0;
    scale_x       = -24'sd6000;
    scale_y       = 24'sd5975;
    bad_cnt       = 0;
    calm          = 1'b0;
    hold_req      = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (vec_tab[k]) send_word(vec_tab[k].rx, vec_tab[k].ry, vec_tab[k].want);
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      sx = 24'($urandom);
      sy = 24'($urandom);
      case (ph)
        0: begin sx = 24'h7FFFFF; sy = 24'h800000; end
        1: begin sx = 24'h800000; sy = 24'h7FFFFF; end
        2: begin sx = 24'h000000; sy = 24'h000000; end
        3: begin sx = 24'h000001; sy = 24'hFFFFFF; end
        4: sx = 24'h000000;
        5: begin sx = -24'sd6000; sy = 24'sd5975; end
        default: ;
      endcase
      load_scales(sx, sy);
      calm = (ph == 6);
      if (ph == 1 || ph == 5) hold_req = 1'b1;
      repeat (PHASE_WORDS) send_word(pick_raw(), pick_raw(), FROM_MODEL);
      drain();
    end
    calm = 1'b0;

    repeat (STEPS + 10) @(posedge clk_i);
    if (heading_q.size() != 0) bad_cnt++;
    if (bad_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
